>>> rtl/fss_pkg.sv
// Shared constants, command codes and control structs for the Floyd sampler.
package fss_pkg;

    localparam int unsigned MAX_CASES = 64;
    localparam int unsigned ID_WIDTH  = 32;
    localparam int unsigned CNT_W     = $clog2(MAX_CASES + 1);
    localparam int unsigned ADDR_W    = (MAX_CASES > 1) ? $clog2(MAX_CASES) : 1;
    localparam int unsigned DIV_STEPS = 64;
    localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);

    localparam logic [63:0] SM_INC  = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] SM_MUL1 = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [63:0] SM_MUL2 = 64'h94d0_49bb_1331_11eb;

    localparam int unsigned SH_A = 30;
    localparam int unsigned SH_B = 27;
    localparam int unsigned SH_C = 31;

    // Datapath micro-operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ERR,
        OP_LIM_INIT,
        OP_DIV_STEP,
        OP_SAVE_LIM,
        OP_GEN,
        OP_MUL_LL,
        OP_MUL_LH,
        OP_MUL_HL,
        OP_SHIFT_MIX,
        OP_FINISH,
        OP_SCAN_INIT,
        OP_SCAN_RD,
        OP_SCAN_CMP,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic stage;     // selects the second mixing multiplier
        logic next_cur;  // advance the current bound
    } cmd_t;

    typedef struct packed {
        logic bad;
        logic div_last;
        logic accept;
        logic scan_end;
        logic done;
    } stat_t;

endpackage

>>> rtl/fss_ctrl.sv
// Sequencer for the Floyd sampler: issues datapath micro-operations.
module fss_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    input  fss_pkg::stat_t stat,
    output fss_pkg::cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_REQ, S_LINIT, S_LDIV, S_LSAVE, S_GEN,
        S_M1A, S_M1B, S_M1C, S_SH,
        S_M2A, S_M2B, S_M2C, S_FIN, S_CHK, S_VDIV,
        S_SINIT, S_SCAN, S_SCMP, S_OUT
    } state_t;

    state_t state_reg, state_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    // Decode next state and command
    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = fss_pkg::OP_NONE;
        cmd.stage    = 1'b0;
        cmd.next_cur = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = fss_pkg::OP_LOAD;
                    state_next = S_REQ;
                end
            end
            S_REQ:
            begin
                if (stat.bad)
                begin
                    cmd.op     = fss_pkg::OP_ERR;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_LINIT;
                end
            end
            S_LINIT:
            begin
                cmd.op     = fss_pkg::OP_LIM_INIT;
                state_next = S_LDIV;
            end
            S_LDIV:
            begin
                cmd.op = fss_pkg::OP_DIV_STEP;
                if (stat.div_last)
                    state_next = S_LSAVE;
            end
            S_LSAVE:
            begin
                cmd.op     = fss_pkg::OP_SAVE_LIM;
                state_next = S_GEN;
            end
            S_GEN:
            begin
                cmd.op     = fss_pkg::OP_GEN;
                state_next = S_M1A;
            end
            S_M1A:
            begin
                cmd.op     = fss_pkg::OP_MUL_LL;
                state_next = S_M1B;
            end
            S_M1B:
            begin
                cmd.op     = fss_pkg::OP_MUL_LH;
                state_next = S_M1C;
            end
            S_M1C:
            begin
                cmd.op     = fss_pkg::OP_MUL_HL;
                state_next = S_SH;
            end
            S_SH:
            begin
                cmd.op     = fss_pkg::OP_SHIFT_MIX;
                state_next = S_M2A;
            end
            S_M2A:
            begin
                cmd.op     = fss_pkg::OP_MUL_LL;
                cmd.stage  = 1'b1;
                state_next = S_M2B;
            end
            S_M2B:
            begin
                cmd.op     = fss_pkg::OP_MUL_LH;
                cmd.stage  = 1'b1;
                state_next = S_M2C;
            end
            S_M2C:
            begin
                cmd.op     = fss_pkg::OP_MUL_HL;
                cmd.stage  = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.op     = fss_pkg::OP_FINISH;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                // Reject values below the limit and draw again
                state_next = stat.accept ? S_VDIV : S_GEN;
            end
            S_VDIV:
            begin
                cmd.op = fss_pkg::OP_DIV_STEP;
                if (stat.div_last)
                    state_next = S_SINIT;
            end
            S_SINIT:
            begin
                cmd.op     = fss_pkg::OP_SCAN_INIT;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (stat.scan_end)
                begin
                    cmd.op     = fss_pkg::OP_EMIT;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.op     = fss_pkg::OP_SCAN_RD;
                    state_next = S_SCMP;
                end
            end
            S_SCMP:
            begin
                cmd.op     = fss_pkg::OP_SCAN_CMP;
                state_next = S_SCAN;
            end
            S_OUT:
            begin
                // Hold the result until its transfer
                if (!out_stall)
                begin
                    if (stat.done)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.next_cur = 1'b1;
                        state_next   = S_LINIT;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> rtl/fss_dp.sv
// Datapath for the Floyd sampler: generator, shared multiplier, divider, id store.
module fss_dp (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [63:0]             seed_value,
    input  logic [31:0]             population_size,
    input  logic [6:0]              case_count,
    input  fss_pkg::cmd_t           cmd,
    output fss_pkg::stat_t          stat,
    output logic [31:0]             case_id,
    output logic                    last_of_run,
    output logic                    bad_request
);

    localparam int unsigned IW = fss_pkg::ID_WIDTH;

    logic [63:0]                 gen_reg;
    logic [63:0]                 x_reg;
    logic [63:0]                 acc_reg;
    logic [63:0]                 dvd_reg;
    logic [IW-1:0]               rem_reg;
    logic [IW-1:0]               limit_reg;
    logic [IW-1:0]               bound_reg;
    logic [IW-1:0]               cur_reg;
    logic [IW-1:0]               pop_reg;
    logic [IW-1:0]               cand_reg;
    logic [IW-1:0]               rd_reg;
    logic                        hit_reg;
    logic                        bad_reg;
    logic [fss_pkg::DCNT_W-1:0]  dcnt_reg;
    logic [fss_pkg::CNT_W-1:0]   idx_reg;
    logic [fss_pkg::CNT_W-1:0]   chosen_reg;
    logic [IW-1:0]               id_out_reg;
    logic                        last_reg;
    logic                        badout_reg;
    logic [IW-1:0]               mem [fss_pkg::MAX_CASES];

    logic [IW-1:0]               pop_in;
    logic                        bad_in;
    logic [63:0]                 gen_sum;
    logic [63:0]                 mul_k;
    logic [31:0]                 mul_a;
    logic [31:0]                 mul_b;
    logic [63:0]                 prod;
    logic [IW:0]                 div_t;
    logic                        div_ge;
    logic [IW-1:0]               bound_new;
    logic [IW-1:0]               id_pick;

    // Decode the request
    assign pop_in = population_size[IW-1:0];
    assign bad_in = (case_count == 7'd0)
                 || (64'(case_count) > 64'(pop_in))
                 || (64'(case_count) > 64'(fss_pkg::MAX_CASES));

    assign gen_sum = gen_reg + fss_pkg::SM_INC;

    // Shared 32x32 multiplier for the low 64 bits of a 64x64 product
    assign mul_k = cmd.stage ? fss_pkg::SM_MUL2 : fss_pkg::SM_MUL1;
    always_comb
    begin
        unique case (cmd.op)
            fss_pkg::OP_MUL_LH:
            begin
                mul_a = x_reg[31:0];
                mul_b = mul_k[63:32];
            end
            fss_pkg::OP_MUL_HL:
            begin
                mul_a = x_reg[63:32];
                mul_b = mul_k[31:0];
            end
            default:
            begin
                mul_a = x_reg[31:0];
                mul_b = mul_k[31:0];
            end
        endcase
    end
    assign prod = 64'(mul_a) * 64'(mul_b);

    // One restoring division step
    assign div_t  = {rem_reg, dvd_reg[63]};
    assign div_ge = (div_t >= {1'b0, bound_reg});

    assign bound_new = cur_reg + IW'(1);
    assign id_pick   = hit_reg ? cur_reg : cand_reg;

    assign stat.bad      = bad_reg;
    assign stat.div_last = (dcnt_reg == fss_pkg::DCNT_W'(fss_pkg::DIV_STEPS - 1));
    assign stat.accept   = (dvd_reg >= 64'(limit_reg));
    assign stat.scan_end = (idx_reg == chosen_reg);
    assign stat.done     = last_reg;

    assign case_id     = 32'(id_out_reg);
    assign last_of_run = last_reg;
    assign bad_request = badout_reg;

    // Advance the datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg    <= '0;
            x_reg      <= '0;
            acc_reg    <= '0;
            dvd_reg    <= '0;
            rem_reg    <= '0;
            limit_reg  <= '0;
            bound_reg  <= '0;
            pop_reg    <= '0;
            cand_reg   <= '0;
            rd_reg     <= '0;
            hit_reg    <= 1'b0;
            dcnt_reg   <= '0;
            idx_reg    <= '0;
            chosen_reg <= '0;
            cur_reg    <= '0;
            bad_reg    <= 1'b0;
            last_reg   <= 1'b0;
            badout_reg <= 1'b0;
            id_out_reg <= '0;
        end
        else
        begin
            if (cmd.next_cur)
                cur_reg <= bound_new;
            unique case (cmd.op)
                fss_pkg::OP_LOAD:
                begin
                    gen_reg    <= seed_value;
                    pop_reg    <= pop_in;
                    cur_reg    <= pop_in - IW'(case_count);
                    bad_reg    <= bad_in;
                    chosen_reg <= '0;
                end
                fss_pkg::OP_ERR:
                begin
                    id_out_reg <= '0;
                    last_reg   <= 1'b1;
                    badout_reg <= 1'b1;
                end
                fss_pkg::OP_LIM_INIT:
                begin
                    bound_reg <= bound_new;
                    dvd_reg   <= 64'd0 - 64'(bound_new);
                    rem_reg   <= '0;
                    dcnt_reg  <= '0;
                end
                fss_pkg::OP_DIV_STEP:
                begin
                    rem_reg  <= div_ge ? IW'(div_t - {1'b0, bound_reg}) : div_t[IW-1:0];
                    dvd_reg  <= {dvd_reg[62:0], 1'b0};
                    dcnt_reg <= dcnt_reg + fss_pkg::DCNT_W'(1);
                end
                fss_pkg::OP_SAVE_LIM:
                begin
                    limit_reg <= rem_reg;
                end
                fss_pkg::OP_GEN:
                begin
                    gen_reg <= gen_sum;
                    x_reg   <= gen_sum ^ (gen_sum >> fss_pkg::SH_A);
                end
                fss_pkg::OP_MUL_LL:
                begin
                    acc_reg <= prod;
                end
                fss_pkg::OP_MUL_LH, fss_pkg::OP_MUL_HL:
                begin
                    acc_reg[63:32] <= acc_reg[63:32] + prod[31:0];
                end
                fss_pkg::OP_SHIFT_MIX:
                begin
                    x_reg <= acc_reg ^ (acc_reg >> fss_pkg::SH_B);
                end
                fss_pkg::OP_FINISH:
                begin
                    dvd_reg  <= acc_reg ^ (acc_reg >> fss_pkg::SH_C);
                    rem_reg  <= '0;
                    dcnt_reg <= '0;
                end
                fss_pkg::OP_SCAN_INIT:
                begin
                    cand_reg <= rem_reg;
                    idx_reg  <= '0;
                    hit_reg  <= 1'b0;
                end
                fss_pkg::OP_SCAN_RD:
                begin
                    rd_reg <= mem[idx_reg[fss_pkg::ADDR_W-1:0]];
                end
                fss_pkg::OP_SCAN_CMP:
                begin
                    hit_reg <= hit_reg | (rd_reg == cand_reg);
                    idx_reg <= idx_reg + fss_pkg::CNT_W'(1);
                end
                fss_pkg::OP_EMIT:
                begin
                    id_out_reg <= id_pick;
                    last_reg   <= (bound_new == pop_reg);
                    badout_reg <= 1'b0;
                    chosen_reg <= chosen_reg + fss_pkg::CNT_W'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    // Store each chosen id
    always_ff @(posedge clk)
    begin
        if (cmd.op == fss_pkg::OP_EMIT)
            mem[chosen_reg[fss_pkg::ADDR_W-1:0]] <= id_pick;
    end

endmodule

>>> rtl/floyd_sample_splitmix.sv
// Top level of the Floyd sampler with a SplitMix64 source.
// Each request draws case_count distinct ids below population_size and returns them one
// per transfer, the last marked by last_of_run; a bad count gives one result with
// bad_request set. One request is worked at a time. Each draw computes the rejection
// limit (a one-bit-per-cycle 64-step divider), then draws generator values (three
// 32x32 partial products per 64-bit multiply on one shared multiplier) until one is
// accepted, reduces it through the same divider and scans the id memory of the ids
// already chosen for a duplicate.
module floyd_sample_splitmix (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] seed_value,
    input  logic [31:0] population_size,
    input  logic [6:0]  case_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] case_id,
    output logic        last_of_run,
    output logic        bad_request
);

    fss_pkg::cmd_t  cmd;
    fss_pkg::stat_t stat;

    fss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    fss_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .seed_value      (seed_value),
        .population_size (population_size),
        .case_count      (case_count),
        .cmd             (cmd),
        .stat            (stat),
        .case_id         (case_id),
        .last_of_run     (last_of_run),
        .bad_request     (bad_request)
    );

endmodule
